[src/rbps_pkg.sv]
`timescale 1ns / 1ps
package rbps_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned RATIO_W = 24;
  localparam int unsigned VALUE_W = 49;
  localparam int unsigned SVAL_W  = 48;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned DIV_W   = 48;
  localparam int unsigned MW      = 64;
  localparam int unsigned WIDE_W  = 128;

  localparam logic [CIDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BAND_MULT  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_START_VAL  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_START_POS  = 2'd3;

  localparam logic [POS_W-1:0] POS_FLAT  = 2'd0;
  localparam logic [POS_W-1:0] POS_LONGA = 2'd1;
  localparam logic [POS_W-1:0] POS_SHRTA = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDIV,
    ST_RWAIT,
    ST_CHECK,
    ST_RDOLD,
    ST_GA,
    ST_GAWAIT,
    ST_GB,
    ST_GBWAIT,
    ST_FACT,
    ST_VMUL,
    ST_VMWAIT,
    ST_VSAT,
    ST_MEAN,
    ST_MWAIT,
    ST_LQ,
    ST_LQWAIT,
    ST_SS,
    ST_SSWAIT,
    ST_KV,
    ST_KVWAIT,
    ST_D2,
    ST_D2WAIT,
    ST_DECIDE,
    ST_PUSH,
    ST_SQ,
    ST_SQWAIT,
    ST_RSQ,
    ST_UPD,
    ST_OUT
  } rbps_state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } rbps_ctl_t;

endpackage

[src/rbps_stream_if.sv]
`timescale 1ns / 1ps
interface rbps_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/rbps_ram.sv]
`timescale 1ns / 1ps
module rbps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/rbps_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rbps_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbps_pkg::rbps_ctl_t       ctl,
  input  logic [rbps_pkg::DIV_W-1:0] num,
  input  logic [rbps_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [rbps_pkg::DIV_W-1:0] quo
);
  import rbps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic [DIV_W:0]   trial;

  assign trial = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};

  always_comb begin
    quo_nxt = quo_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctl.start) begin
      quo_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = run_r && (cnt_r == CNT_W'(1)) && !ctl.start;
  assign quo  = quo_nxt;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> run_r)
    else $error("divider did not start");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !ctl.start && cnt_r != CNT_W'(1)) |=> run_r)
    else $error("divider stopped early");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !run_r || $past(ctl.start))
    else $error("divider ran past its last step");
endmodule

[src/rbps_mul.sv]
`timescale 1ns / 1ps
// Shift-add multiplier, 64x64 -> 128, four multiplier bits per cycle
// using one 64x4 partial product.
module rbps_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rbps_pkg::rbps_ctl_t         ctl,
  input  logic [rbps_pkg::MW-1:0]     op_a,
  input  logic [rbps_pkg::MW-1:0]     op_b,
  output logic                        done,
  output logic [rbps_pkg::WIDE_W-1:0] prod
);
  import rbps_pkg::*;

  localparam int unsigned STEP   = 4;
  localparam int unsigned NSTEPS = MW / STEP;
  localparam int unsigned CNT_W  = $clog2(NSTEPS + 1);

  logic [MW-1:0]     a_r, a_nxt;
  logic [MW-1:0]     b_r, b_nxt;
  logic [WIDE_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic [MW+STEP-1:0] pp;

  assign pp = a_r * b_r[MW-1 -: STEP];

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctl.start) begin
      a_nxt   = op_a;
      b_nxt   = op_b;
      acc_nxt = '0;
      cnt_nxt = CNT_W'(NSTEPS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = {acc_r[WIDE_W-STEP-1:0], {STEP{1'b0}}} + WIDE_W'(pp);
      b_nxt   = {b_r[MW-STEP-1:0], {STEP{1'b0}}};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = run_r && (cnt_r == CNT_W'(1)) && !ctl.start;
  assign prod = acc_nxt;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> run_r && cnt_r == CNT_W'(NSTEPS))
    else $error("multiplier did not load");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && cnt_r != CNT_W'(1) && !ctl.start) |=> run_r)
    else $error("multiplier stopped early");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> !done)
    else $error("done without a run");
endmodule

[src/ratio_band_pair_signal.sv]
`timescale 1ns / 1ps
// Work per item, from the accept to the result valid or the input ready again: one
// division and two squares for a filling item, four divisions and seven products for a
// full-window item, none for a zero price; an item that gives a result also waits for
// the result register to empty.
// One item at a time; the arithmetic runs on the shared bit-serial divider and the
// 4-bit shift-add multiplier, one operation at a time.
// Reset (synchronous, rst_n low): control registers to reset codes, window empty.
module ratio_band_pair_signal #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rbps_stream_if.sink                    in_ch,
  rbps_stream_if.source                  out_ch,
  input  logic                           cfg_we,
  input  logic [rbps_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rbps_pkg::CFG_W-1:0]     cfg_data
);
  import rbps_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);

  // registers
  logic [6:0]        win_len_r;
  logic [3:0]        band_r;
  logic [LEN_W-1:0]  len_eff;

  logic [AW-1:0]     head_r, head_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [PRICE_W-1:0] pa_prev_r, pb_prev_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;

  rbps_state_t       st_r, st_nxt;
  logic [PRICE_W-1:0] pa_r, pb_r;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic [RATIO_W-1:0] mean_r, mean_nxt;
  logic [RATIO_W-1:0] old_r, old_nxt;
  logic [DIV_W-1:0]  ga_r, ga_nxt;
  logic [WIDE_W-1:0] t0_r, t0_nxt;
  logic [WIDE_W-1:0] t1_r, t1_nxt;
  logic [SQ_W-1:0]   dmag_r, dmag_nxt;
  logic              dneg_r, dneg_nxt;
  logic              dpos_r, dpos_nxt;
  logic              vneg_r, vneg_nxt;
  logic [SQ_W-1:0]   fmag_r, fmag_nxt;
  logic              flt_r, flt_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;

  logic [SQ_W-1:0]   old_sq;

  // shared units
  rbps_ctl_t          div_ctl, mul_ctl;
  logic [DIV_W-1:0]   div_num, div_den, div_q;
  logic               div_done;
  logic [MW-1:0]      mul_a, mul_b;
  logic [WIDE_W-1:0]  mul_p;
  logic               mul_done;

  rbps_div u_div (
    .clk (clk), .rst_n (rst_n), .ctl (div_ctl), .num (div_num), .den (div_den),
    .done (div_done), .quo (div_q)
  );
  rbps_mul u_mul (
    .clk (clk), .rst_n (rst_n), .ctl (mul_ctl), .op_a (mul_a), .op_b (mul_b),
    .done (mul_done), .prod (mul_p)
  );

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [RATIO_W-1:0] ram_rd;

  rbps_ram #(.WIDTH (RATIO_W), .DEPTH (MAX_WINDOW)) u_ring (
    .clk (clk), .we (ram_we), .waddr (head_r), .wdata (ratio_r),
    .raddr (ram_addr), .rdata (ram_rd)
  );
  assign ram_addr = head_r;

  always_comb begin
    if (win_len_r < 7'd2) begin
      len_eff = LEN_W'(2);
    end else if ({25'd0, win_len_r} > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(win_len_r);
    end
  end

  logic full;
  assign full = (fill_r >= len_eff);

  // value saturation helpers
  logic [WIDE_W-1:0] vprod_sh;
  logic              vneg_res;
  logic [SQ_W-1:0]   vlimit;
  logic [SQ_W-1:0]   vmag;
  assign vprod_sh = t0_r >> 16;
  assign vneg_res = vneg_r;
  assign vlimit   = vneg_res ? 64'h1_0000_0000_0000 : 64'h0_FFFF_FFFF_FFFF;
  assign vmag     = (vprod_sh[WIDE_W-1:SQ_W] != '0 || vprod_sh[SQ_W-1:0] > vlimit)
                    ? vlimit : vprod_sh[SQ_W-1:0];

  logic signed [SQ_W:0] fact_s;
  logic [SQ_W-1:0] dlen;

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    ratio_nxt = ratio_r;
    mean_nxt  = mean_r;
    old_nxt   = old_r;
    ga_nxt    = ga_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    dmag_nxt  = dmag_r;
    dneg_nxt  = dneg_r;
    dpos_nxt  = dpos_r;
    vneg_nxt  = vneg_r;
    fmag_nxt  = fmag_r;
    flt_nxt   = flt_r;
    ovalid_nxt = ovalid_r;
    opos_nxt  = opos_r;
    div_ctl   = '0;
    mul_ctl   = '0;
    div_num   = '0;
    div_den   = 48'd1;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    old_sq    = '0;
    fact_s    = '0;
    dlen      = '0;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data[PRICE_W-1:0] == '0 || in_ch.data[2*PRICE_W-1:PRICE_W] == '0) begin
            flt_nxt   = 1'b1;
            ratio_nxt = '0;
            mean_nxt  = '0;
            st_nxt    = ST_OUT;
          end else begin
            flt_nxt = 1'b0;
            st_nxt  = ST_RDIV;
          end
        end
      end
      ST_RDIV: begin
        div_ctl.start = 1'b1;
        div_num = {pa_r, 16'd0};
        div_den = {16'd0, pb_r};
        st_nxt  = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_done) begin
          ratio_nxt = (div_q > 48'hFF_FFFF) ? '1 : div_q[RATIO_W-1:0];
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ({1'b0, head_r} >= len_eff) begin
          head_nxt = '0;
        end
        st_nxt = full ? ST_RDOLD : ST_PUSH;
      end
      ST_RDOLD: begin
        st_nxt = ST_GA;
      end
      ST_GA: begin
        old_nxt = ram_rd;
        div_ctl.start = 1'b1;
        div_num = {pa_r, 16'd0};
        div_den = (pa_prev_r == '0) ? 48'd1 : {16'd0, pa_prev_r};
        st_nxt = ST_GAWAIT;
      end
      ST_GAWAIT: begin
        if (div_done) begin
          ga_nxt = (pa_prev_r == '0) ? 48'd65536 : div_q;
          st_nxt = ST_GB;
        end
      end
      ST_GB: begin
        div_ctl.start = 1'b1;
        div_num = {pb_r, 16'd0};
        div_den = (pb_prev_r == '0) ? 48'd1 : {16'd0, pb_prev_r};
        st_nxt = ST_GBWAIT;
      end
      ST_GBWAIT: begin
        if (div_done) begin
          t1_nxt = WIDE_W'((pb_prev_r == '0) ? 48'd65536 : div_q);
          st_nxt = ST_FACT;
        end
      end
      ST_FACT: begin
        if (pos_r == POS_LONGA) begin
          fact_s = $signed({17'd0, ga_r}) - $signed({17'd0, t1_r[DIV_W-1:0]}) + 65'sd65536;
        end else if (pos_r == POS_SHRTA) begin
          fact_s = $signed({17'd0, t1_r[DIV_W-1:0]}) - $signed({17'd0, ga_r}) + 65'sd65536;
        end else begin
          fact_s = 65'sd65536;
        end
        fmag_nxt = fact_s[SQ_W] ? SQ_W'(-fact_s) : fact_s[SQ_W-1:0];
        vneg_nxt = val_r[VALUE_W-1] ^ fact_s[SQ_W];
        st_nxt = ST_VMUL;
      end
      ST_VMUL: begin
        mul_ctl.start = 1'b1;
        mul_a = val_r[VALUE_W-1] ? SQ_W'(65'h2_0000_0000_0000 - {16'd0, val_r})
                                 : {15'd0, val_r};
        mul_b = fmag_r;
        st_nxt = ST_VMWAIT;
      end
      ST_VMWAIT: begin
        if (mul_done) begin
          t0_nxt = mul_p;
          st_nxt = ST_VSAT;
        end
      end
      ST_VSAT: begin
        // magnitude truncated toward zero and saturated, then sign applied
        val_nxt = vneg_r ? VALUE_W'(SQ_W'(0) - vmag) : VALUE_W'(vmag);
        st_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        div_ctl.start = 1'b1;
        div_num = DIV_W'(sum_r);
        div_den = DIV_W'(len_eff);
        dlen = SQ_W'(len_eff) * SQ_W'(ratio_r);
        dneg_nxt = dlen < SQ_W'(sum_r);
        dpos_nxt = dlen > SQ_W'(sum_r);
        dmag_nxt = (dlen < SQ_W'(sum_r)) ? SQ_W'(sum_r) - dlen : dlen - SQ_W'(sum_r);
        st_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (div_done) begin
          mean_nxt = div_q[RATIO_W-1:0];
          st_nxt = ST_LQ;
        end
      end
      ST_LQ: begin
        mul_ctl.start = 1'b1;
        mul_a = SQ_W'(len_eff);
        mul_b = sq_r;
        st_nxt = ST_LQWAIT;
      end
      ST_LQWAIT: begin
        if (mul_done) begin
          t0_nxt = mul_p;
          st_nxt = ST_SS;
        end
      end
      ST_SS: begin
        mul_ctl.start = 1'b1;
        mul_a = SQ_W'(sum_r);
        mul_b = SQ_W'(sum_r);
        st_nxt = ST_SSWAIT;
      end
      ST_SSWAIT: begin
        if (mul_done) begin
          t0_nxt = t0_r - mul_p;
          st_nxt = ST_KV;
        end
      end
      ST_KV: begin
        // var stays below 2^64 for 24-bit ratios over a 64-entry window
        mul_ctl.start = 1'b1;
        mul_a = t0_r[SQ_W-1:0];
        mul_b = SQ_W'(band_r) * SQ_W'(band_r);
        st_nxt = ST_KVWAIT;
      end
      ST_KVWAIT: begin
        if (mul_done) begin
          t0_nxt = mul_p;
          st_nxt = ST_D2;
        end
      end
      ST_D2: begin
        mul_ctl.start = 1'b1;
        mul_a = dmag_r;
        mul_b = dmag_r;
        st_nxt = ST_D2WAIT;
      end
      ST_D2WAIT: begin
        if (mul_done) begin
          t1_nxt = mul_p;
          st_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (t1_r > t0_r && dpos_r) begin
          pos_nxt = POS_SHRTA;
        end else if (t1_r > t0_r && dneg_r) begin
          pos_nxt = POS_LONGA;
        end else begin
          pos_nxt = POS_FLAT;
        end
        st_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        // drop the oldest ratio from the sums when the window is full
        if (full) begin
          sum_nxt = sum_r - SUM_W'(old_r);
        end
        st_nxt = ST_SQ;
      end
      ST_SQ: begin
        mul_ctl.start = 1'b1;
        mul_a = full ? SQ_W'(old_r) : '0;
        mul_b = full ? SQ_W'(old_r) : '0;
        st_nxt = ST_SQWAIT;
      end
      ST_SQWAIT: begin
        if (mul_done) begin
          t1_nxt = mul_p;
          st_nxt = ST_RSQ;
        end
      end
      ST_RSQ: begin
        mul_ctl.start = 1'b1;
        mul_a = SQ_W'(ratio_r);
        mul_b = SQ_W'(ratio_r);
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (mul_done) begin
          old_sq = t1_r[SQ_W-1:0];
          sq_nxt = sq_r - old_sq + mul_p[SQ_W-1:0];
          sum_nxt = sum_r + SUM_W'(ratio_r);
          ram_we = 1'b1;
          if (!full) begin
            fill_nxt = fill_r + 1'b1;
          end
          head_nxt = ({1'b0, head_r} + 1'b1 >= len_eff) ? '0 : head_r + 1'b1;
          if (full) begin
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        // hold the position with the other result fields until the transfer
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          opos_nxt = pos_r;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (st_r == ST_IDLE);

  logic [VALUE_W-1:0] oval_r;
  logic [RATIO_W-1:0] orat_r, omean_r;
  logic               oflt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      win_len_r <= 7'd30;
      band_r    <= 4'd2;
      head_r    <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
      pa_prev_r <= '0;
      pb_prev_r <= '0;
      pos_r     <= POS_LONGA;
      val_r     <= VALUE_W'(48'd65536000);
      ovalid_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ovalid_r <= ovalid_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
      sq_r     <= sq_nxt;
      pos_r    <= pos_nxt;
      val_r    <= val_nxt;
      if (st_r == ST_UPD && mul_done) begin
        pa_prev_r <= pa_r;
        pb_prev_r <= pb_r;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            win_len_r <= cfg_data[6:0];
            head_r <= '0;
            fill_r <= '0;
            sum_r  <= '0;
            sq_r   <= '0;
          end
          REG_BAND_MULT: band_r <= cfg_data[3:0];
          REG_START_VAL: val_r <= {1'b0, cfg_data[SVAL_W-1:0]};
          REG_START_POS: pos_r <= (cfg_data[1:0] == 2'd3) ? POS_FLAT : cfg_data[1:0];
          default: ;
        endcase
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      pa_r <= in_ch.data[PRICE_W-1:0];
      pb_r <= in_ch.data[2*PRICE_W-1:PRICE_W];
    end
    ratio_r <= ratio_nxt;
    mean_r  <= mean_nxt;
    old_r   <= old_nxt;
    ga_r    <= ga_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    dmag_r  <= dmag_nxt;
    dneg_r  <= dneg_nxt;
    dpos_r  <= dpos_nxt;
    vneg_r  <= vneg_nxt;
    fmag_r  <= fmag_nxt;
    flt_r   <= flt_nxt;
    opos_r  <= opos_nxt;
    if (st_r == ST_OUT && (!ovalid_r || out_ch.ready)) begin
      oval_r  <= val_r;
      orat_r  <= ratio_r;
      omean_r <= mean_r;
      oflt_r  <= flt_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = {oflt_r, omean_r, orat_r, oval_r, opos_r};

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(MAX_WINDOW))
    else $error("fill count beyond window");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ch.ready)
    else $error("input taken while busy");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("invalid held position");
endmodule
